FILE: hdl/skis_pkg.sv
package skis_pkg;

   // Store geometry
   localparam int MAX_KEYS   = 1024;
   localparam int KEY_BITS   = 16;
   localparam int STORE_SIZE = MAX_KEYS + 1;
   localparam int ADDR_BITS  = $clog2(STORE_SIZE);

   // Fixed field widths
   localparam int CSR_BITS   = 11;
   localparam int SLOT_BITS  = 11;
   localparam int FIELD_BITS = 16;
   localparam int INDEX_BITS = 10;

   // Seed product: count times Q0.16 fraction
   localparam int PROD_BITS  = ADDR_BITS + FIELD_BITS;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // One classified request waiting for the back end
   typedef struct packed {
      logic                  is_query;
      logic                  slot_ok;
      logic [ADDR_BITS-1:0]  slot;
      logic [KEY_BITS-1:0]   key;
      logic [FIELD_BITS-1:0] target;
      logic [ADDR_BITS-1:0]  seed;
   } item_type;

   // Queue handshake toward the back end
   typedef struct packed {
      logic     empty;
      item_type head;
   } queue_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_CHK_S,
      ST_CHK_S1,
      ST_PROBE,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/skis_front.sv
module skis_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_cmd,
   input  logic [skis_pkg::SLOT_BITS-1:0]      req_load_slot,
   input  logic [skis_pkg::FIELD_BITS-1:0]     req_key_value,
   input  logic [skis_pkg::FIELD_BITS-1:0]     req_frame_fraction,
   input  logic [skis_pkg::FIELD_BITS-1:0]     req_target_key,
   input  logic [skis_pkg::ADDR_BITS-1:0]      eff_count,
   input  logic                                q_pop,
   output skis_pkg::queue_type                 q_out
);

   skis_pkg::item_type                  queue_ff [skis_pkg::QUEUE_DEPTH];
   skis_pkg::item_type                  item_in;
   logic [skis_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [skis_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [skis_pkg::QCNT_BITS-1:0]      count_ff, count_in;
   logic [skis_pkg::PROD_BITS-1:0]      product;
   logic [skis_pkg::ADDR_BITS-1:0]      seed_raw;
   logic [skis_pkg::ADDR_BITS-1:0]      seed_max;
   logic                                push_ok;
   logic                                pop_ok;

   // Seed the first probe: floor(count * fraction), held below count
   always_comb begin
      product  = skis_pkg::PROD_BITS'(eff_count) * skis_pkg::PROD_BITS'(req_frame_fraction);
      seed_raw = product[skis_pkg::PROD_BITS-1:skis_pkg::FIELD_BITS];
      seed_max = eff_count - skis_pkg::ADDR_BITS'(1);
   end

   // Classify the request
   always_comb begin
      item_in.is_query = (req_cmd == skis_pkg::CMD_QUERY);
      item_in.slot_ok  = (32'(req_load_slot) <= 32'(skis_pkg::MAX_KEYS));
      item_in.slot     = skis_pkg::ADDR_BITS'(req_load_slot);
      item_in.key      = req_key_value[skis_pkg::KEY_BITS-1:0];
      item_in.target   = req_target_key;
      item_in.seed     = (seed_raw > seed_max) ? seed_max : seed_raw;
   end

   // Advance pointers and fill count
   always_comb begin
      push_ok   = req_push && !req_full;
      pop_ok    = q_pop && !q_out.empty;
      wr_ptr_in = wr_ptr_ff + skis_pkg::QPTR_BITS'(push_ok);
      rd_ptr_in = rd_ptr_ff + skis_pkg::QPTR_BITS'(pop_ok);
      count_in  = count_ff + skis_pkg::QCNT_BITS'(push_ok) - skis_pkg::QCNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified request
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign req_full    = (count_ff == skis_pkg::QCNT_BITS'(skis_pkg::QUEUE_DEPTH));
   assign q_out.empty = (count_ff == '0);
   assign q_out.head  = queue_ff[rd_ptr_ff];

endmodule

FILE: hdl/skis_back.sv
module skis_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [skis_pkg::ADDR_BITS-1:0]      eff_count,
   input  skis_pkg::queue_type                 q_in,
   output logic                                q_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [skis_pkg::INDEX_BITS-1:0]     rsp_interval_index,
   output logic                                rsp_out_of_range
);

   skis_pkg::state_type                 state_ff, state_in;

   logic [skis_pkg::KEY_BITS-1:0]       key_mem_ff [skis_pkg::STORE_SIZE];
   logic [skis_pkg::KEY_BITS-1:0]       rd_data_ff;
   logic [skis_pkg::ADDR_BITS-1:0]      rd_addr;
   logic                                mem_we;

   logic [skis_pkg::FIELD_BITS-1:0]     tgt_ff, tgt_in;
   logic [skis_pkg::ADDR_BITS-1:0]      seed_ff, seed_in;
   logic [skis_pkg::ADDR_BITS-1:0]      lo_ff, lo_in;
   logic [skis_pkg::ADDR_BITS-1:0]      hi_ff, hi_in;
   logic [skis_pkg::INDEX_BITS-1:0]     res_idx_ff, res_idx_in;
   logic                                res_flag_ff, res_flag_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [skis_pkg::INDEX_BITS-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                                rsp_flag_ff, rsp_flag_in;

   logic [skis_pkg::ADDR_BITS-1:0]      span;
   logic [skis_pkg::ADDR_BITS-1:0]      mid;
   logic                                t_lt;
   logic                                out_free;
   logic                                rsp_load;
   logic                                take_query;

   // Compare target against the key just read
   always_comb begin
      t_lt       = tgt_ff < skis_pkg::FIELD_BITS'(rd_data_ff);
      span       = hi_ff - lo_ff;
      mid        = lo_ff + (span >> 1);
      out_free   = !rsp_valid_ff || rsp_pop;
      take_query = !q_in.empty && q_in.head.is_query;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skis_pkg::ST_IDLE:   if (take_query) state_in = skis_pkg::ST_CHK_LO;
         skis_pkg::ST_CHK_LO: state_in = t_lt ? skis_pkg::ST_DONE : skis_pkg::ST_CHK_HI;
         skis_pkg::ST_CHK_HI: state_in = t_lt ? skis_pkg::ST_CHK_S : skis_pkg::ST_DONE;
         skis_pkg::ST_CHK_S:  state_in = t_lt ? skis_pkg::ST_PROBE : skis_pkg::ST_CHK_S1;
         skis_pkg::ST_CHK_S1: state_in = t_lt ? skis_pkg::ST_DONE : skis_pkg::ST_PROBE;
         skis_pkg::ST_PROBE:  state_in = (span > skis_pkg::ADDR_BITS'(1)) ?
                                         skis_pkg::ST_EVAL : skis_pkg::ST_DONE;
         skis_pkg::ST_EVAL:   state_in = skis_pkg::ST_PROBE;
         skis_pkg::ST_DONE:   if (out_free) state_in = skis_pkg::ST_IDLE;
         default:             state_in = skis_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: queue pop, store write, read address, result load
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      rsp_load = 1'b0;
      rd_addr  = '0;
      case (state_ff)
         skis_pkg::ST_IDLE: begin
            q_pop  = !q_in.empty;
            mem_we = !q_in.empty && !q_in.head.is_query && q_in.head.slot_ok;
         end
         skis_pkg::ST_CHK_LO: rd_addr = eff_count;
         skis_pkg::ST_CHK_HI: rd_addr = seed_ff;
         skis_pkg::ST_CHK_S:  rd_addr = seed_ff + skis_pkg::ADDR_BITS'(1);
         skis_pkg::ST_PROBE:  rd_addr = mid;
         skis_pkg::ST_DONE:   rsp_load = out_free;
         default:             rd_addr = '0;
      endcase
   end

   // Bisection datapath
   always_comb begin
      tgt_in      = tgt_ff;
      seed_in     = seed_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      res_idx_in  = res_idx_ff;
      res_flag_in = res_flag_ff;
      case (state_ff)
         skis_pkg::ST_IDLE: begin
            tgt_in  = q_in.head.target;
            seed_in = q_in.head.seed;
         end
         skis_pkg::ST_CHK_LO: begin
            res_idx_in  = '0;
            res_flag_in = 1'b1;
         end
         skis_pkg::ST_CHK_HI: begin
            res_idx_in  = skis_pkg::INDEX_BITS'(eff_count - skis_pkg::ADDR_BITS'(1));
            res_flag_in = 1'b1;
         end
         skis_pkg::ST_CHK_S: begin
            lo_in = '0;
            hi_in = seed_ff;
         end
         skis_pkg::ST_CHK_S1: begin
            res_idx_in  = skis_pkg::INDEX_BITS'(seed_ff);
            res_flag_in = 1'b0;
            lo_in       = seed_ff + skis_pkg::ADDR_BITS'(1);
            hi_in       = eff_count;
         end
         skis_pkg::ST_PROBE: begin
            res_idx_in  = skis_pkg::INDEX_BITS'(lo_ff);
            res_flag_in = 1'b0;
         end
         skis_pkg::ST_EVAL: begin
            if (t_lt) begin
               hi_in = mid;
            end else begin
               lo_in = mid;
            end
         end
         default: begin
            lo_in = lo_ff;
         end
      endcase
   end

   // Result register: load when done, drop on pop
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = res_idx_ff;
         rsp_flag_in  = res_flag_ff;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skis_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      seed_ff     <= seed_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_idx_ff  <= res_idx_in;
      res_flag_ff <= res_flag_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   // Key store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem_ff[q_in.head.slot] <= q_in.head.key;
      end
      rd_data_ff <= key_mem_ff[rd_addr];
   end

   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_interval_index = rsp_idx_ff;
   assign rsp_out_of_range   = rsp_flag_ff;

endmodule

FILE: hdl/seeded_key_interval_search_top.sv
// Seeded key interval search.
// Requests enter through a queue-style port: a request is taken at a clock edge with
// req_push high and req_full low. req_cmd selects a key load (write req_key_value into
// store slot req_load_slot) or a query (find i with key[i] <= req_target_key < key[i+1],
// first probe seeded at floor(key_count * req_frame_fraction / 65536)).
// Each query gives one response on rsp_interval_index / rsp_out_of_range, visible while
// rsp_empty is low and taken at an edge with rsp_pop high; loads give no response.
// key_count is written through csr_valid/csr_ready/csr_data; the user must write it only
// while the block is idle, which the block does not enforce. A four-entry request queue
// separates intake from the search sequencer, so requests are taken while the sequencer
// works or a response waits. A load occupies the sequencer only in its idle state. A query
// compares the target with the lowest and the highest key of the span, then with the keys
// at the seed and one above it, and otherwise bisects the remaining interval. The single
// read port of the key store gives one registered read per probe.
// Reset clears the queue, the sequencer and the response register and sets key_count
// to 1; key store contents are undefined until loaded. A stalled response holds the
// sequencer after its next query; the queue then fills and raises req_full.
module seeded_key_interval_search_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_cmd,
   input  logic [skis_pkg::SLOT_BITS-1:0]      req_load_slot,
   input  logic [skis_pkg::FIELD_BITS-1:0]     req_key_value,
   input  logic [skis_pkg::FIELD_BITS-1:0]     req_frame_fraction,
   input  logic [skis_pkg::FIELD_BITS-1:0]     req_target_key,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [skis_pkg::INDEX_BITS-1:0]     rsp_interval_index,
   output logic                                rsp_out_of_range,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [skis_pkg::CSR_BITS-1:0]       csr_data
);

   logic [skis_pkg::CSR_BITS-1:0]       key_count_ff, key_count_in;
   logic [skis_pkg::ADDR_BITS-1:0]      eff_count;
   skis_pkg::queue_type                 q_link;
   logic                                q_pop;

   // Hold the key count register
   assign csr_ready = 1'b1;

   always_comb begin
      key_count_in = key_count_ff;
      if (csr_valid && csr_ready) begin
         key_count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= skis_pkg::CSR_BITS'(1);
      end else begin
         key_count_ff <= key_count_in;
      end
   end

   // Treat zero as one and clamp to the store size
   always_comb begin
      if (key_count_ff == '0) begin
         eff_count = skis_pkg::ADDR_BITS'(1);
      end else if (32'(key_count_ff) > 32'(skis_pkg::MAX_KEYS)) begin
         eff_count = skis_pkg::ADDR_BITS'(skis_pkg::MAX_KEYS);
      end else begin
         eff_count = skis_pkg::ADDR_BITS'(key_count_ff);
      end
   end

   skis_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_cmd            (req_cmd),
      .req_load_slot      (req_load_slot),
      .req_key_value      (req_key_value),
      .req_frame_fraction (req_frame_fraction),
      .req_target_key     (req_target_key),
      .eff_count          (eff_count),
      .q_pop              (q_pop),
      .q_out              (q_link)
   );

   skis_back u_back (
      .clock              (clock),
      .reset              (reset),
      .eff_count          (eff_count),
      .q_in               (q_link),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_interval_index (rsp_interval_index),
      .rsp_out_of_range   (rsp_out_of_range)
   );

   // An out-of-range response names one of the two end intervals
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_of_range) |->
         (rsp_interval_index == '0) ||
         (rsp_interval_index == skis_pkg::INDEX_BITS'(eff_count - skis_pkg::ADDR_BITS'(1))))
      else $error("out-of-range response not at an end interval");

   // Every response lies inside the configured span
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (32'(rsp_interval_index) < 32'(eff_count)))
      else $error("response index beyond key count");

   // Reset leaves no response pending
   assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response pending after reset");

endmodule
